// ----- hdl/pcomp_pkg.sv -----
// Package for the pressure/temperature compensation block: calibration register
// indexes, stage payload types and the truncating shift helper.
// Used by every module of the block; depends on nothing.
package pcomp_pkg;

  // Calibration register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } reg_index_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned TEMP_W     = 19;
  localparam int unsigned PRES_W     = 32;
  localparam int unsigned WIDE_W     = 40;

  // Shift amounts of the first-order and pressure scaling.
  localparam logic [5:0] SENS_SHIFT  = 6'd8;
  localparam logic [5:0] OFF_SHIFT   = 6'd7;
  localparam logic [5:0] TEMP_SHIFT  = 6'd23;
  localparam logic [5:0] PROD_SHIFT  = 6'd21;
  localparam logic [5:0] PRES_SHIFT  = 6'd13;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = 19'sd1500;

  localparam logic signed [63:0] PRES_MAX = 64'sd2147483647;
  localparam logic signed [63:0] PRES_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pressure_sensitivity;
    logic [CFG_DATA_W-1:0] pressure_offset;
    logic [CFG_DATA_W-1:0] sensitivity_temp_coeff;
    logic [CFG_DATA_W-1:0] offset_temp_coeff;
    logic [CFG_DATA_W-1:0] reference_temperature;
    logic [CFG_DATA_W-1:0] temperature_coeff;
  } cfg_t;

  // First-order results on their way to the second-order correction.
  typedef struct packed {
    logic [RAW_W-1:0]         raw_pressure;
    logic signed [WIDE_W-1:0] sens;
    logic signed [WIDE_W-1:0] off;
    logic signed [TEMP_W-1:0] temp;
    logic [16:0]              ti_low;
    logic [12:0]              ti_high;
  } fo_t;

  // Corrected values handed to the pressure scaling.
  typedef struct packed {
    logic [RAW_W-1:0]         raw_pressure;
    logic signed [WIDE_W-1:0] sens2;
    logic signed [WIDE_W-1:0] off2;
    logic signed [TEMP_W-1:0] temp2;
  } so_t;

  // Arithmetic right shift that rounds toward zero, as a signed division
  // by a power of two does.
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                   input logic [5:0] sh);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

// ----- hdl/pressure_temp_compensation.sv -----
// Fully pipelined pressure/temperature compensation with second-order
// correction. A reading pair is taken on every cycle in which start is high;
// busy is always low, because the ten-stage datapath has no loop and takes one
// beat per clock. The result of a beat is on the out_ ports, with out_valid
// high for one cycle, as it leaves the output registers; the pipeline depth
// is set by the three 64-bit sign-correct scaling adds and the split
// 24x40-bit pressure multiply. Results come in the order the beats went in.
// Calibration words must be written on the cfg_ port only while no beat
// is in flight; the block itself does not enforce this.
// Depends on pcomp_pkg and the pcomp_* stage modules.
module pressure_temp_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcomp_pkg::RAW_W-1:0]         in_raw_pressure,
  input  logic [pcomp_pkg::RAW_W-1:0]         in_raw_temperature,
  output logic                                out_valid,
  output logic signed [pcomp_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic signed [pcomp_pkg::PRES_W-1:0] out_pressure_deci_mbar,
  input  logic                                cfg_we,
  input  logic [pcomp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcomp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pcomp_pkg::*;

  cfg_t cfg;
  logic fo_valid;
  fo_t  fo;
  logic so_valid;
  so_t  so;
  logic in_accept;

  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  pcomp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcomp_first_order u_first_order (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_accept),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .cfg             (cfg),
    .fo_valid        (fo_valid),
    .fo              (fo)
  );

  pcomp_second_order u_second_order (
    .clk      (clk),
    .rst_n    (rst_n),
    .fo_valid (fo_valid),
    .fo       (fo),
    .so_valid (so_valid),
    .so       (so)
  );

  pcomp_pressure u_pressure (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .so_valid               (so_valid),
    .so                     (so),
    .out_valid              (out_valid),
    .out_temperature_centi  (out_temperature_centi),
    .out_pressure_deci_mbar (out_pressure_deci_mbar)
  );

endmodule

// ----- hdl/pcomp_cfg_regs.sv -----
// Calibration register file of the compensation block.
// Depends on pcomp_pkg for the register indexes and the cfg_t bundle.
module pcomp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pcomp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcomp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output pcomp_pkg::cfg_t                     cfg
);
  import pcomp_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PRESSURE_SENSITIVITY:   cfg_nxt.pressure_sensitivity   = cfg_wdata;
        REG_PRESSURE_OFFSET:        cfg_nxt.pressure_offset        = cfg_wdata;
        REG_SENSITIVITY_TEMP_COEFF: cfg_nxt.sensitivity_temp_coeff = cfg_wdata;
        REG_OFFSET_TEMP_COEFF:      cfg_nxt.offset_temp_coeff      = cfg_wdata;
        REG_REFERENCE_TEMPERATURE:  cfg_nxt.reference_temperature  = cfg_wdata;
        REG_TEMPERATURE_COEFF:      cfg_nxt.temperature_coeff      = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/pcomp_first_order.sv -----
// First-order compensation: temperature difference, its products with the
// calibration words, and sensitivity, offset and temperature. Three stages.
// Depends on pcomp_pkg.
module pcomp_first_order (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [pcomp_pkg::RAW_W-1:0]     raw_pressure,
  input  logic [pcomp_pkg::RAW_W-1:0]     raw_temperature,
  input  pcomp_pkg::cfg_t                 cfg,
  output logic                            fo_valid,
  output pcomp_pkg::fo_t                  fo
);
  import pcomp_pkg::*;

  // Stage 1: temperature difference.
  logic                    v1_r;
  logic [RAW_W-1:0]        d1_1_r;
  logic signed [24:0]      dt_r, dt_nxt;

  // Stage 2: products of dt.
  logic                    v2_r;
  logic [RAW_W-1:0]        d1_2_r;
  logic signed [41:0]      prod_sens_r, prod_sens_nxt;
  logic signed [41:0]      prod_off_r, prod_off_nxt;
  logic signed [41:0]      prod_temp_r, prod_temp_nxt;
  logic signed [49:0]      dtsq_full;
  logic [48:0]             dtsq_r, dtsq_nxt;

  // Stage 3: scaled first-order values.
  logic                    v3_r;
  fo_t                     fo_r, fo_nxt;
  logic signed [63:0]      sens64, off64, temp64;
  logic [49:0]             dtsq3;

  always_comb begin
    dt_nxt = $signed({1'b0, raw_temperature})
           - $signed({1'b0, cfg.reference_temperature, 8'h00});
  end

  always_comb begin
    prod_sens_nxt = $signed({1'b0, cfg.sensitivity_temp_coeff}) * dt_r;
    prod_off_nxt  = $signed({1'b0, cfg.offset_temp_coeff}) * dt_r;
    prod_temp_nxt = $signed({1'b0, cfg.temperature_coeff}) * dt_r;
    dtsq_full     = dt_r * dt_r;
    dtsq_nxt      = dtsq_full[48:0];
  end

  always_comb begin
    sens64 = $signed({33'd0, cfg.pressure_sensitivity, 15'd0})
           + trunc_shr({{22{prod_sens_r[41]}}, prod_sens_r}, SENS_SHIFT);
    off64  = $signed({32'd0, cfg.pressure_offset, 16'd0})
           + trunc_shr({{22{prod_off_r[41]}}, prod_off_r}, OFF_SHIFT);
    temp64 = {{45{TEMP_REF[TEMP_W-1]}}, TEMP_REF}
           + trunc_shr({{22{prod_temp_r[41]}}, prod_temp_r}, TEMP_SHIFT);
    dtsq3  = {dtsq_r, 1'b0} + {1'b0, dtsq_r};

    fo_nxt.raw_pressure = d1_2_r;
    fo_nxt.sens         = sens64[WIDE_W-1:0];
    fo_nxt.off          = off64[WIDE_W-1:0];
    fo_nxt.temp         = temp64[TEMP_W-1:0];
    // Low band: 3*dT^2 / 2^33. High band: 2*dT^2 / 2^37 = dT^2 / 2^36.
    fo_nxt.ti_low       = dtsq3[49:33];
    fo_nxt.ti_high      = dtsq_r[48:36];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dt_r        <= dt_nxt;
    d1_1_r      <= raw_pressure;
    prod_sens_r <= prod_sens_nxt;
    prod_off_r  <= prod_off_nxt;
    prod_temp_r <= prod_temp_nxt;
    dtsq_r      <= dtsq_nxt;
    d1_2_r      <= d1_1_r;
    fo_r        <= fo_nxt;
  end

  assign fo_valid = v3_r;
  assign fo       = fo_r;

endmodule

// ----- hdl/pcomp_second_order.sv -----
// Second-order correction: band selection, squared deviations, the offset and
// sensitivity corrections, and the corrected temperature. Three stages.
// Depends on pcomp_pkg.
module pcomp_second_order (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fo_valid,
  input  pcomp_pkg::fo_t    fo,
  output logic              so_valid,
  output pcomp_pkg::so_t    so
);
  import pcomp_pkg::*;

  // Stage 4: deviations from the band limits and their squares.
  logic                     v4_r;
  fo_t                      fo4_r;
  logic signed [TEMP_W-1:0] dev, lo;
  logic signed [37:0]       dev_sq_full, lo_sq_full;
  logic [33:0]              dev_sq_r, dev_sq_nxt;
  logic [33:0]              lo_sq_r, lo_sq_nxt;
  logic                     low_r, low_nxt;
  logic                     vlow_r, vlow_nxt;

  // Stage 5: corrections.
  logic                     v5_r;
  logic [RAW_W-1:0]         d1_5_r;
  logic signed [WIDE_W-1:0] sens5_r, off5_r;
  logic [37:0]              offi_r, offi_nxt;
  logic [36:0]              sensi_r, sensi_nxt;
  logic signed [TEMP_W-1:0] temp2_r, temp2_nxt;
  logic [35:0]              dev3;
  logic [36:0]              dev5, lo7;
  logic [35:0]              lo4;

  // Stage 6: corrected offset and sensitivity.
  logic                     v6_r;
  so_t                      so_r, so_nxt;

  always_comb begin
    dev         = fo.temp - TEMP_REF;
    lo          = fo.temp + TEMP_VLOW;
    dev_sq_full = dev * dev;
    lo_sq_full  = lo * lo;
    dev_sq_nxt  = dev_sq_full[33:0];
    lo_sq_nxt   = lo_sq_full[33:0];
    low_nxt     = dev[TEMP_W-1];
    vlow_nxt    = lo[TEMP_W-1];
  end

  always_comb begin
    dev3 = {1'b0, dev_sq_r, 1'b0} + {2'b00, dev_sq_r};
    dev5 = {1'b0, dev_sq_r, 2'b00} + {3'b000, dev_sq_r};
    lo7  = {lo_sq_r, 3'b000} - {3'b000, lo_sq_r};
    lo4  = {lo_sq_r, 2'b00};
    if (low_r) begin
      offi_nxt  = {3'b000, dev3[35:1]} + (vlow_r ? {1'b0, lo7} : 38'd0);
      sensi_nxt = {3'b000, dev5[36:3]} + (vlow_r ? {1'b0, lo4} : 37'd0);
      temp2_nxt = fo4_r.temp - $signed({2'b00, fo4_r.ti_low});
    end else begin
      offi_nxt  = {8'd0, dev_sq_r[33:4]};
      sensi_nxt = '0;
      temp2_nxt = fo4_r.temp - $signed({6'd0, fo4_r.ti_high});
    end
  end

  always_comb begin
    so_nxt.raw_pressure = d1_5_r;
    so_nxt.off2         = off5_r - $signed({2'b00, offi_r});
    so_nxt.sens2        = sens5_r - $signed({3'b000, sensi_r});
    so_nxt.temp2        = temp2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= fo_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    fo4_r    <= fo;
    dev_sq_r <= dev_sq_nxt;
    lo_sq_r  <= lo_sq_nxt;
    low_r    <= low_nxt;
    vlow_r   <= vlow_nxt;
    d1_5_r   <= fo4_r.raw_pressure;
    sens5_r  <= fo4_r.sens;
    off5_r   <= fo4_r.off;
    offi_r   <= offi_nxt;
    sensi_r  <= sensi_nxt;
    temp2_r  <= temp2_nxt;
    so_r     <= so_nxt;
  end

  assign so_valid = v6_r;
  assign so       = so_r;

endmodule

// ----- hdl/pcomp_pressure.sv -----
// Pressure scaling: raw pressure times corrected sensitivity in two partial
// products, offset subtraction, final scaling and saturation. Four stages.
// Depends on pcomp_pkg.
module pcomp_pressure (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                so_valid,
  input  pcomp_pkg::so_t                      so,
  output logic                                out_valid,
  output logic signed [pcomp_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic signed [pcomp_pkg::PRES_W-1:0] out_pressure_deci_mbar
);
  import pcomp_pkg::*;

  // Stage 7: partial products over the low and high halves of sens2.
  logic                     v7_r;
  logic [43:0]              pp_lo_r, pp_lo_nxt;
  logic signed [44:0]       pp_hi_r, pp_hi_nxt;
  logic signed [WIDE_W-1:0] off2_7_r;
  logic signed [TEMP_W-1:0] temp2_7_r;

  // Stage 8: full product.
  logic                     v8_r;
  logic signed [63:0]       prod_r, prod_nxt;
  logic signed [WIDE_W-1:0] off2_8_r;
  logic signed [TEMP_W-1:0] temp2_8_r;

  // Stage 9: scaled product minus offset.
  logic                     v9_r;
  logic signed [63:0]       q64;
  logic signed [47:0]       q_r;
  logic signed [TEMP_W-1:0] temp2_9_r;

  // Stage 10: output registers.
  logic                     v10_r;
  logic signed [63:0]       p64;
  logic signed [PRES_W-1:0] pres_r, pres_nxt;
  logic signed [TEMP_W-1:0] temp_out_r;

  always_comb begin
    pp_lo_nxt = so.raw_pressure * so.sens2[19:0];
    pp_hi_nxt = $signed({1'b0, so.raw_pressure}) * $signed(so.sens2[WIDE_W-1:20]);
  end

  always_comb begin
    prod_nxt = ($signed({{19{pp_hi_r[44]}}, pp_hi_r}) <<< 20)
             + $signed({20'd0, pp_lo_r});
  end

  always_comb begin
    q64 = trunc_shr(prod_r, PROD_SHIFT)
        - $signed({{24{off2_8_r[WIDE_W-1]}}, off2_8_r});
  end

  always_comb begin
    p64 = trunc_shr({{16{q_r[47]}}, q_r}, PRES_SHIFT);
    priority if (p64 > PRES_MAX) begin
      pres_nxt = PRES_MAX[PRES_W-1:0];
    end else if (p64 < PRES_MIN) begin
      pres_nxt = PRES_MIN[PRES_W-1:0];
    end else begin
      pres_nxt = p64[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else begin
      v7_r  <= so_valid;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo_r    <= pp_lo_nxt;
    pp_hi_r    <= pp_hi_nxt;
    off2_7_r   <= so.off2;
    temp2_7_r  <= so.temp2;
    prod_r     <= prod_nxt;
    off2_8_r   <= off2_7_r;
    temp2_8_r  <= temp2_7_r;
    q_r        <= q64[47:0];
    temp2_9_r  <= temp2_8_r;
    pres_r     <= pres_nxt;
    temp_out_r <= temp2_9_r;
  end

  assign out_valid              = v10_r;
  assign out_temperature_centi  = temp_out_r;
  assign out_pressure_deci_mbar = pres_r;

endmodule

// ----- tb/pcomp_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the pressure/temperature compensation testbench: it keeps a
// copy of the calibration words, predicts each compensated reading and checks results.
// Depends on pcomp_pkg for widths and register indexes.
package pcomp_tb_pkg;
  import pcomp_pkg::*;

  localparam int NUM_CAL_WORDS = 6;
  // Indexes past the last calibration word; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_deci_mbar;
  } compensated_t;

  class pcomp_scoreboard;
    longint cal_word [NUM_CAL_WORDS];
    compensated_t compensated_q [$];
    int mismatches;

    function new();
      foreach (cal_word[i]) cal_word[i] = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx < NUM_CAL_WORDS) cal_word[idx] = {48'd0, value};
    endfunction

    function int pending();
      return compensated_q.size();
    endfunction

    // First-order compensation, then the second-order correction of the
    // temperature band. Signed 64-bit division truncates toward zero.
    function compensated_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
      longint d1, d2, dt, sens, off, temp, dev, lo, ti, offi, sensi, p, temp2;
      compensated_t r;
      d1 = {40'd0, d1_raw};
      d2 = {40'd0, d2_raw};
      dt = d2 - cal_word[REG_REFERENCE_TEMPERATURE] * 256;
      sens = cal_word[REG_PRESSURE_SENSITIVITY] * 32768
             + (cal_word[REG_SENSITIVITY_TEMP_COEFF] * dt) / 256;
      off = cal_word[REG_PRESSURE_OFFSET] * 65536
            + (cal_word[REG_OFFSET_TEMP_COEFF] * dt) / 128;
      temp = 2000 + (dt * cal_word[REG_TEMPERATURE_COEFF]) / 8388608;
      dev = temp - 2000;
      if (temp < 2000) begin
        ti = (3 * dt * dt) / 64'sd8589934592;
        offi = (3 * dev * dev) / 2;
        sensi = (5 * dev * dev) / 8;
        if (temp < -1500) begin
          lo = temp + 1500;
          offi += 7 * lo * lo;
          sensi += 4 * lo * lo;
        end
      end else begin
        ti = (2 * dt * dt) / 64'sd137438953472;
        offi = (dev * dev) / 16;
        sensi = 0;
      end
      p = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;
      if (p > PRES_MAX) p = PRES_MAX;
      if (p < PRES_MIN) p = PRES_MIN;
      temp2 = temp - ti;
      r.temperature_centi = temp2[TEMP_W-1:0];
      r.pressure_deci_mbar = p[PRES_W-1:0];
      return r;
    endfunction

    function void note_reading(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      compensated_q.push_back(compensate(d1, d2));
    endfunction

    function void check_result(logic signed [TEMP_W-1:0] temperature_centi,
                               logic signed [PRES_W-1:0] pressure_deci_mbar);
      compensated_t e;
      if (compensated_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none outstanding: temperature %0d pressure %0d",
                 $time, temperature_centi, pressure_deci_mbar);
        return;
      end
      e = compensated_q.pop_front();
      if (temperature_centi !== e.temperature_centi) begin
        mismatches++;
        $display("%0t: temperature_centi expected %0d, actual %0d",
                 $time, e.temperature_centi, temperature_centi);
      end
      if (pressure_deci_mbar !== e.pressure_deci_mbar) begin
        mismatches++;
        $display("%0t: pressure_deci_mbar expected %0d, actual %0d",
                 $time, e.pressure_deci_mbar, pressure_deci_mbar);
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_pressure_temp_compensation.sv -----
`timescale 1ns / 100ps
// Top-level testbench for pressure_temp_compensation: directed readings at the
// band edges and extremes, then randomly calibrated phases of random readings.
// Depends on pcomp_pkg, pcomp_tb_pkg and the RTL of the block.
module tb_pressure_temp_compensation;
  import pcomp_pkg::*;
  import pcomp_tb_pkg::*;

  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int MAX_GAP         = 13;
  localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [RAW_W-1:0] in_raw_pressure = '0;
  logic [RAW_W-1:0] in_raw_temperature = '0;
  logic out_valid;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic signed [PRES_W-1:0] out_pressure_deci_mbar;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pcomp_scoreboard sb = new();
  logic [CFG_DATA_W-1:0] cal_words [NUM_CAL_WORDS];
  int burst_left = 0;
  int cycles = 0;

  pressure_temp_compensation dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_raw_pressure        (in_raw_pressure),
    .in_raw_temperature     (in_raw_temperature),
    .out_valid              (out_valid),
    .out_temperature_centi  (out_temperature_centi),
    .out_pressure_deci_mbar (out_pressure_deci_mbar),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_temperature_centi, out_pressure_deci_mbar);
  end

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One beat, then the idle gap drawn for it. Now and then the sender holds
  // off until every outstanding result is back.
  task automatic drive_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int gap;
    start <= 1'b1;
    in_raw_pressure <= d1;
    in_raw_temperature <= d2;
    do @(posedge clk); while (busy);
    sb.note_reading(d1, d2);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 40);
    end
    if ($urandom_range(0, 149) == 0) begin
      start <= 1'b0;
      wait_drained();
    end else if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Calibration words change only with nothing in flight.
  task automatic recalibrate(input logic [CFG_DATA_W-1:0] words [NUM_CAL_WORDS]);
    reg_index_t idx;
    start <= 1'b0;
    wait_drained();
    repeat (12) @(posedge clk);
    for (int i = 0; i < NUM_CAL_WORDS; i++) begin
      idx = reg_index_t'(i);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= words[i];
      @(posedge clk);
      sb.set_register(idx, words[i]);
      cal_words[i] = words[i];
    end
    cfg_index <= SPARE_INDEX_LO;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= SPARE_INDEX_HI;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] words [NUM_CAL_WORDS];
    logic [RAW_W-1:0] d1, d2;
    longint centre, near;
    int pick;

    foreach (cal_words[i]) cal_words[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: every word zero, so every reading is in the high band.
    drive_reading('0, '0);
    drive_reading(RAW_MAX, RAW_MAX);
    drive_reading(RAW_MAX, '0);
    drive_reading('0, RAW_MAX);

    foreach (words[i]) words[i] = '1;
    recalibrate(words);
    drive_reading('0, '0);
    drive_reading(RAW_MAX, RAW_MAX);
    drive_reading(RAW_MAX, '0);
    drive_reading('0, RAW_MAX);
    drive_reading(RAW_MAX, 24'd16776960);

    // With both reference and coefficient at 32768 the temperature moves one
    // hundredth per 256 counts of the temperature reading, which puts the band
    // edges on exact readings: 20.00 C just above 8388352, -15.00 C at 7492608.
    words[REG_PRESSURE_SENSITIVITY]   = 16'd34982;
    words[REG_PRESSURE_OFFSET]        = 16'd36352;
    words[REG_SENSITIVITY_TEMP_COEFF] = 16'd20328;
    words[REG_OFFSET_TEMP_COEFF]      = 16'd22354;
    words[REG_REFERENCE_TEMPERATURE]  = 16'd32768;
    words[REG_TEMPERATURE_COEFF]      = 16'd32768;
    recalibrate(words);
    drive_reading(RAW_MAX, 24'd8388353);
    drive_reading(24'h555555, 24'd8388352);
    drive_reading(24'hAAAAAA, 24'd7492608);
    drive_reading(24'd8000000, 24'd7492352);
    drive_reading(24'd6000000, 24'd8388608);
    drive_reading('0, 24'd8388863);
    drive_reading(RAW_MAX, '0);
    drive_reading(24'd1, RAW_MAX);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      foreach (words[i]) begin
        pick = $urandom_range(0, 7);
        words[i] = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_DATA_W'($urandom);
      end
      recalibrate(words);
      centre = {40'd0, cal_words[REG_REFERENCE_TEMPERATURE], 8'd0};
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 7);
        d1 = (pick == 0) ? '0 : (pick == 1) ? RAW_MAX : RAW_W'($urandom);
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
          d2 = (pick == 0) ? '0 : RAW_MAX;
        end else if (pick < 5) begin
          // Close to the reference, where the temperature sits near 20 C.
          near = centre + longint'($urandom_range(0, 8191)) - 4096;
          if (near < 0) near = 0;
          if (near > RAW_MAX) near = RAW_MAX;
          d2 = near[RAW_W-1:0];
        end else begin
          d2 = RAW_W'($urandom);
        end
        drive_reading(d1, d2);
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
